@@ design/cpack_word_encoder_core_assert.svh @@
// Assertion macros for the C-Pack word encoder.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef CPACK_WORD_ENCODER_CORE_ASSERT_SVH
`define CPACK_WORD_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPWE_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPWE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cpwe_pkg.sv @@
// Shared constants and types for the C-Pack word encoder.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package cpwe_pkg;

    localparam int DATA_W      = 32;
    localparam int CODE_W      = 34;
    localparam int BITS_W      = 6;
    localparam int PAT_W       = 3;
    localparam int IDX_FIELD_W = 4;

    // Index field is 4 bits, so no more than 16 entries are ever used.
    localparam int IDX_LIMIT      = 16;
    localparam int DICT_DEPTH_DEF = 16;

    // Pattern codes
    localparam logic [PAT_W-1:0] PAT_ZZZZ = 3'd0;
    localparam logic [PAT_W-1:0] PAT_ZZZX = 3'd1;
    localparam logic [PAT_W-1:0] PAT_MMMM = 3'd2;
    localparam logic [PAT_W-1:0] PAT_MMMX = 3'd3;
    localparam logic [PAT_W-1:0] PAT_MMXX = 3'd4;
    localparam logic [PAT_W-1:0] PAT_XXXX = 3'd5;

    // Code prefixes
    localparam logic [1:0] PFX_ZZZZ = 2'b00;
    localparam logic [3:0] PFX_ZZZX = 4'b1101;
    localparam logic [1:0] PFX_MMMM = 2'b10;
    localparam logic [3:0] PFX_MMMX = 4'b1110;
    localparam logic [3:0] PFX_MMXX = 4'b1100;
    localparam logic [1:0] PFX_XXXX = 2'b01;

    // Code lengths
    localparam logic [BITS_W-1:0] LEN_ZZZZ = 6'd2;
    localparam logic [BITS_W-1:0] LEN_ZZZX = 6'd12;
    localparam logic [BITS_W-1:0] LEN_MMMM = 6'd6;
    localparam logic [BITS_W-1:0] LEN_MMMX = 6'd16;
    localparam logic [BITS_W-1:0] LEN_MMXX = 6'd24;
    localparam logic [BITS_W-1:0] LEN_XXXX = 6'd34;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [BITS_W-1:0] code_bits;
        logic [PAT_W-1:0]  pattern;
    } cpwe_result_t;

endpackage

`default_nettype wire

@@ design/cpwe_if.sv @@
// Valid/ready channel interfaces for the C-Pack word encoder.
// Depends on cpwe_pkg for the payload widths.
`default_nettype none

interface cpwe_word_if
    import cpwe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_word;
    logic              line_start;

    modport source (output valid, output data_word, output line_start, input ready);
    modport sink   (input valid, input data_word, input line_start, output ready);
endinterface

interface cpwe_code_if
    import cpwe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_word;
    logic [BITS_W-1:0] code_bits;
    logic [PAT_W-1:0]  pattern;

    modport source (output valid, output code_word, output code_bits, output pattern,
                    input ready);
    modport sink   (input valid, input code_word, input code_bits, input pattern,
                    output ready);
endinterface

`default_nettype wire

@@ design/cpack_word_encoder_core.sv @@
// C-Pack word encoder core: dictionary, match logic and code formation.
// Depends on cpwe_pkg, cpwe_if.sv and cpack_word_encoder_core_assert.svh.
`default_nettype none
`include "cpack_word_encoder_core_assert.svh"

// One 32-bit word per transaction in, one C-Pack code per transaction out.
// Throughput is one word per clock unless the output stalls; each word passes
// an input register, then a result register. Between them every dictionary entry
// is compared in parallel against the word, the longest leading-byte match is
// picked (lowest index wins a tie), the code is formed and the dictionary,
// write pointer and fill count are updated, so the next word sees this one.
// A word with line_start set empties the dictionary before it is encoded.
// Zero patterns (zzzz, zzzx, the latter covering 0x01..0xFF) are never
// stored. The dictionary holds min(DICT_DEPTH, 16) entries in flops and
// needs no clearing pass: only entries below the fill count are compared.
// While the output is stalled one more word is held in the input register.
module cpack_word_encoder_core
    import cpwe_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
)
(
    input  wire          clk,
    input  wire          rst_n,
    cpwe_word_if.sink    words,
    cpwe_code_if.source  codes
);

    localparam int EFF_DEPTH = (DICT_DEPTH > IDX_LIMIT) ? IDX_LIMIT : DICT_DEPTH;
    localparam int IDX_W     = $clog2(EFF_DEPTH);
    localparam int CNT_W     = $clog2(EFF_DEPTH + 1);

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(EFF_DEPTH);
    localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(EFF_DEPTH - 1);

    // Input stage
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_word_reg;
    logic              in_start_reg;

    // Dictionary and its FIFO control
    logic [DATA_W-1:0] dict_reg [EFF_DEPTH];
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;

    // Result stage
    logic         res_valid_reg;
    cpwe_result_t res_reg, res_next;

    logic             advance;
    logic             in_ready;
    logic             push;
    logic [CNT_W-1:0] fill_eff;
    logic [IDX_W-1:0] wptr_eff;

    logic [EFF_DEPTH-1:0] ge2_vec, ge3_vec, ge4_vec, sel_vec;
    logic [IDX_W-1:0]     best_idx;
    logic [IDX_FIELD_W-1:0] idx_field;

    // Lowest set bit wins.
    function automatic logic [IDX_W-1:0] lowest_set(input logic [EFF_DEPTH-1:0] vec);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int i = EFF_DEPTH - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // Handshake: result stage frees when empty or taken.
    assign advance  = !res_valid_reg || codes.ready;
    assign in_ready = !in_valid_reg || advance;

    assign words.ready = in_ready;
    assign codes.valid = res_valid_reg;
    assign codes.code_word = res_reg.code_word;
    assign codes.code_bits = res_reg.code_bits;
    assign codes.pattern   = res_reg.pattern;

    // Line start empties the dictionary before the compare.
    assign fill_eff = in_start_reg ? '0 : fill_count_reg;
    assign wptr_eff = in_start_reg ? '0 : wr_ptr_reg;

    // Zero patterns stay out of the dictionary.
    assign push = (in_word_reg[DATA_W-1:8] != '0);

    // Parallel compare, masked by fill count.
    always_comb
    begin
        for (int i = 0; i < EFF_DEPTH; i++)
        begin
            ge2_vec[i] = (CNT_W'(i) < fill_eff) &&
                         (dict_reg[i][DATA_W-1:16] == in_word_reg[DATA_W-1:16]);
            ge3_vec[i] = ge2_vec[i] && (dict_reg[i][15:8] == in_word_reg[15:8]);
            ge4_vec[i] = ge3_vec[i] && (dict_reg[i][7:0] == in_word_reg[7:0]);
        end
    end

    // Lowest index at the longest match level is also the first to reach it.
    assign sel_vec   = (|ge4_vec) ? ge4_vec : ((|ge3_vec) ? ge3_vec : ge2_vec);
    assign best_idx  = lowest_set(sel_vec);
    assign idx_field = IDX_FIELD_W'(best_idx);

    always_comb
    begin
        if (in_word_reg == '0)
        begin
            res_next.pattern = PAT_ZZZZ;
        end
        else if (!push)
        begin
            res_next.pattern = PAT_ZZZX;
        end
        else if (|ge4_vec)
        begin
            res_next.pattern = PAT_MMMM;
        end
        else if (|ge3_vec)
        begin
            res_next.pattern = PAT_MMMX;
        end
        else if (|ge2_vec)
        begin
            res_next.pattern = PAT_MMXX;
        end
        else
        begin
            res_next.pattern = PAT_XXXX;
        end

        case (res_next.pattern)
            PAT_ZZZZ:
            begin
                res_next.code_word = {{(CODE_W-2){1'b0}}, PFX_ZZZZ};
                res_next.code_bits = LEN_ZZZZ;
            end
            PAT_ZZZX:
            begin
                res_next.code_word = {{(CODE_W-12){1'b0}}, PFX_ZZZX, in_word_reg[7:0]};
                res_next.code_bits = LEN_ZZZX;
            end
            PAT_MMMM:
            begin
                res_next.code_word = {{(CODE_W-6){1'b0}}, PFX_MMMM, idx_field};
                res_next.code_bits = LEN_MMMM;
            end
            PAT_MMMX:
            begin
                res_next.code_word = {{(CODE_W-16){1'b0}}, PFX_MMMX, idx_field,
                                      in_word_reg[7:0]};
                res_next.code_bits = LEN_MMMX;
            end
            PAT_MMXX:
            begin
                res_next.code_word = {{(CODE_W-24){1'b0}}, PFX_MMXX, idx_field,
                                      in_word_reg[15:0]};
                res_next.code_bits = LEN_MMXX;
            end
            default:
            begin
                res_next.code_word = {PFX_XXXX, in_word_reg};
                res_next.code_bits = LEN_XXXX;
            end
        endcase
    end

    // FIFO pointer and saturating fill count.
    always_comb
    begin
        wr_ptr_next     = wptr_eff;
        fill_count_next = fill_eff;
        if (push)
        begin
            wr_ptr_next = (wptr_eff == PTR_LAST) ? '0 : wptr_eff + 1'b1;
            if (fill_eff != FILL_MAX)
            begin
                fill_count_next = fill_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            fill_count_reg <= '0;
            wr_ptr_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= words.valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                fill_count_reg <= fill_count_next;
                wr_ptr_reg     <= wr_ptr_next;
            end
        end
    end

    // Payload and dictionary storage, no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && words.valid)
        begin
            in_word_reg  <= words.data_word;
            in_start_reg <= words.line_start;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
            if (push)
            begin
                dict_reg[wptr_eff] <= in_word_reg;
            end
        end
    end

    // Checks
    `CPWE_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_count_reg <= FILL_MAX,
        "fill count beyond dictionary depth")
    `CPWE_ASSERT_NOW(a_ptr_tracks_fill, clk, rst_n, fill_count_reg != FILL_MAX,
        wr_ptr_reg == IDX_W'(fill_count_reg), "write pointer out of step with fill count")
    `CPWE_ASSERT_NEXT(a_start_empties, clk, rst_n, advance && in_valid_reg && in_start_reg,
        fill_count_reg <= CNT_W'(1), "line start did not empty the dictionary")
    `CPWE_ASSERT_NEXT(a_zero_no_push, clk, rst_n,
        advance && in_valid_reg && !in_start_reg && !push,
        $stable(fill_count_reg) && $stable(wr_ptr_reg), "zero pattern written to dictionary")
    `CPWE_ASSERT_NOW(a_no_overwrite, clk, rst_n, in_valid_reg && !advance, !words.ready,
        "input register open while result stage is stalled")

endmodule

`default_nettype wire
